FILE: rtl/c32p_pkg.sv
// Shared constants, types and the CRC-32C byte fold for the padded digest block.
`timescale 1ns / 1ps
package c32p_pkg;

	// Message padding alignment in bytes (1 to 16)
	localparam int PAD_ALIGNMENT = 4;
	localparam int PHASE_W = (PAD_ALIGNMENT > 1) ? $clog2(PAD_ALIGNMENT) : 1;
	// One zero-byte fold stage per possible pad byte, at least one stage
	localparam int PAD_STAGES = (PAD_ALIGNMENT > 1) ? PAD_ALIGNMENT - 1 : 1;

	localparam logic [31:0] CRC_POLY_REFL = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_FINAL_XOR = 32'hFFFF_FFFF;

	typedef logic [PHASE_W-1:0] phase_t;

	// Work item moving down the pad pipeline
	typedef struct packed {
		logic        vld;
		logic [31:0] crc;
		phase_t      cnt;
	} pad_item_t;

	// Reflected CRC-32C, one byte: eight shift/xor steps
	function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/c32p_byte_if.sv
// Message byte channel: valid/ready with one byte and a last marker.
`timescale 1ns / 1ps
interface c32p_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/c32p_digest_if.sv
// Digest channel: valid/ready with the 32-bit CRC-32C result.
`timescale 1ns / 1ps
interface c32p_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest;

	modport source (output valid, output digest, input ready);
	modport sink (input valid, input digest, output ready);
endinterface

FILE: rtl/crc32c_padded_digest.sv
// Top level: byte-serial CRC-32C with zero padding to the alignment and final inversion.
//
// Usage:
//   msg carries one message byte per transfer (data_byte) with last_byte set
//   on the final byte of each message. Every message has at least one byte.
//   dig carries one digest per message: the reflected CRC-32C (init all ones)
//   of the message followed by zero bytes up to the next multiple of
//   PAD_ALIGNMENT bytes, inverted.
// Throughput: one byte per cycle, sustained across message boundaries, while
//   dig.ready keeps the output register draining (see Stalls).
// Path: a last byte moves from the input register through the PAD_STAGES
//   zero-byte fold stages into the output register; padding always walks
//   the full pad pipeline.
// Stalls: while dig.ready is low the digest holds in the output register;
//   the pad stages and input register fill behind it, and msg.ready drops
//   only once a last byte cannot move into a full pad pipeline. Non-last
//   bytes keep flowing as long as the input register drains.
// Reset: arst_n clears all valid flags, sets the running CRC to all ones
//   and the byte phase to zero. After each last byte the running state
//   returns to those values for the next message.
`timescale 1ns / 1ps
module crc32c_padded_digest (
	input logic           clk,
	input logic           arst_n,
	c32p_byte_if.sink     msg,
	c32p_digest_if.source dig
);
	import c32p_pkg::*;

	// Input register
	logic       vld_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Running message state
	logic [31:0] crc_q;
	phase_t      phase_q;

	// Output register
	logic        out_vld_q;
	logic [31:0] digest_q;

	pad_item_t   pad_link [PAD_STAGES+1];
	logic        pad_rdy  [PAD_STAGES+1];

	logic        s1_go;
	logic        out_go;
	logic [31:0] crc_fold;
	phase_t      phase_nxt;
	phase_t      pad_cnt;

	// Byte fold, phase advance and pad count for the byte in s1
	always_comb begin
		crc_fold = fold_byte(crc_q, data_s1);
		if (PAD_ALIGNMENT == 1 || phase_q == phase_t'(PAD_ALIGNMENT - 1)) begin
			phase_nxt = '0;
		end else begin
			phase_nxt = phase_q + phase_t'(1);
		end
		if (phase_nxt == '0) begin
			pad_cnt = '0;
		end else begin
			pad_cnt = phase_t'(PAD_ALIGNMENT - int'(phase_nxt));
		end
	end

	// s1 drains unless a last byte waits on the pad pipeline
	assign s1_go     = vld_s1 && (!last_s1 || pad_rdy[0]);
	assign msg.ready = !vld_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (msg.ready) begin
			vld_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			data_s1 <= msg.data_byte;
			last_s1 <= msg.last_byte;
		end
	end

	// Running CRC and phase; restart after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			phase_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				crc_q   <= CRC_INIT;
				phase_q <= '0;
			end else begin
				crc_q   <= crc_fold;
				phase_q <= phase_nxt;
			end
		end
	end

	// Entry into the pad pipeline: only last bytes create a work item
	assign pad_link[0].vld = vld_s1 && last_s1;
	assign pad_link[0].crc = crc_fold;
	assign pad_link[0].cnt = pad_cnt;

	for (genvar g = 0; g < PAD_STAGES; g++) begin : g_pad
		c32p_pad_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up       (pad_link[g]),
			.up_ready (pad_rdy[g]),
			.dn       (pad_link[g+1]),
			.dn_ready (pad_rdy[g+1])
		);
	end

	// Output register with final inversion
	assign out_go              = !out_vld_q || dig.ready;
	assign pad_rdy[PAD_STAGES] = out_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_go) begin
			out_vld_q <= pad_link[PAD_STAGES].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_go && pad_link[PAD_STAGES].vld) begin
			digest_q <= pad_link[PAD_STAGES].crc ^ CRC_FINAL_XOR;
		end
	end

	assign dig.valid  = out_vld_q;
	assign dig.digest = digest_q;

	// A consumed last byte restarts the running state
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (crc_q == CRC_INIT && phase_q == '0))
		else $error("running state not restarted after last byte");

	// All padding is folded before the output register
	a_pad_done: assert property (@(posedge clk) disable iff (!arst_n)
		pad_link[PAD_STAGES].vld |-> (pad_link[PAD_STAGES].cnt == '0))
		else $error("pad bytes left at end of pad pipeline");

	// Phase stays below the alignment
	a_phase_rng: assert property (@(posedge clk) disable iff (!arst_n)
		int'(phase_q) < PAD_ALIGNMENT)
		else $error("byte phase out of range");

	// A held digest blocks the last pad stage from advancing
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !dig.ready) |-> !pad_rdy[PAD_STAGES])
		else $error("pad pipeline advanced into a stalled output");

endmodule

FILE: rtl/c32p_pad_stage.sv
// One pipeline stage that folds a zero pad byte when pad bytes remain.
`timescale 1ns / 1ps
module c32p_pad_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c32p_pkg::pad_item_t  up,
	output logic                 up_ready,
	output c32p_pkg::pad_item_t  dn,
	input  logic                 dn_ready
);
	import c32p_pkg::*;

	logic        vld_q;
	logic [31:0] crc_q;
	phase_t      cnt_q;

	// Stage takes a new item when empty or when its item moves on
	assign up_ready = !vld_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up.vld) begin
			crc_q <= up.crc;
			cnt_q <= up.cnt;
		end
	end

	// Fold one zero byte while padding is still owed
	always_comb begin
		dn.vld = vld_q;
		if (cnt_q != '0) begin
			dn.crc = fold_byte(crc_q, 8'h00);
			dn.cnt = cnt_q - phase_t'(1);
		end else begin
			dn.crc = crc_q;
			dn.cnt = cnt_q;
		end
	end

endmodule

FILE: sim/crc32c_padded_digest_test.sv
// Testbench for crc32c_padded_digest: random byte messages checked against a CRC-32C predictor.
`timescale 1ns / 1ps
module crc32c_padded_digest_test;
	import c32p_pkg::PAD_ALIGNMENT;
	import c32p_pkg::PAD_STAGES;
	import c32p_pkg::CRC_POLY_REFL;
	import c32p_pkg::CRC_INIT;
	import c32p_pkg::CRC_FINAL_XOR;

	localparam int TARGET_BYTES = 1700;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = PAD_STAGES + 8;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} msg_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	c32p_byte_if   msg();
	c32p_digest_if dig();

	crc32c_padded_digest dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.dig    (dig)
	);

	msg_byte_t   pending_bytes[$];
	logic [31:0] expected_digests[$];

	// Predictor state: running CRC and message length modulo the alignment
	logic [31:0] crc_accum;
	int unsigned len_phase;

	int unsigned bytes_accepted = 0;
	int unsigned digests_checked = 0;
	int unsigned messages_queued = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic        byte_taken = 1'b0;

	always #6 clk = ~clk;

	// Reflected CRC-32C update by one byte, LSB first
	function automatic logic [31:0] crc32c_shift_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (r[0] ? CRC_POLY_REFL : 32'd0);
		end
		return r;
	endfunction

	// Queue one message; the last byte carries the marker
	task automatic queue_message(input logic [7:0] bytes[$]);
		msg_byte_t item;
		foreach (bytes[i]) begin
			item.data = bytes[i];
			item.last = (i == bytes.size() - 1);
			pending_bytes.push_back(item);
		end
		messages_queued++;
	endtask

	// Random message: mostly short, sometimes long, with occasional flat fills
	task automatic queue_random_message();
		logic [7:0] bytes[$];
		int unsigned len;
		int unsigned sel;
		int unsigned fill;
		sel = $urandom_range(99);
		if (sel < 80)
			len = $urandom_range(1, 12);
		else if (sel < 95)
			len = $urandom_range(13, 40);
		else
			len = $urandom_range(41, 100);
		fill = $urandom_range(9);
		for (int i = 0; i < len; i++) begin
			case (fill)
				0: begin
					bytes.push_back(8'h00);
				end
				1: begin
					bytes.push_back(8'hFF);
				end
				default: begin
					bytes.push_back(8'($urandom));
				end
			endcase
		end
		queue_message(bytes);
	endtask

	// Pacing: sender-light/receiver-heavy, then reversed, then none
	always_comb begin
		if (bytes_accepted < TARGET_BYTES / 3) begin
			send_idle_pct = 29;
			recv_idle_pct = 71;
		end else if (bytes_accepted < 2 * TARGET_BYTES / 3) begin
			send_idle_pct = 71;
			recv_idle_pct = 29;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	end

	// Byte driver and digest ready, updated at the falling edge
	always @(negedge clk) begin : byte_driver
		msg_byte_t nxt;
		if (arst_n) begin
			dig.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (!msg.valid || byte_taken) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_bytes.pop_front();
					msg.valid     <= 1'b1;
					msg.data_byte <= nxt.data;
					msg.last_byte <= nxt.last;
				end else begin
					msg.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predict on byte transfers, check on digest transfers
	always @(posedge clk) begin : monitor
		logic [31:0] crc;
		logic [31:0] want;
		int unsigned pad;
		byte_taken <= msg.valid && msg.ready;
		if (!arst_n) begin
			crc_accum = CRC_INIT;
			len_phase = 0;
		end else begin
			if (msg.valid && msg.ready) begin
				bytes_accepted++;
				crc_accum = crc32c_shift_byte(crc_accum, msg.data_byte);
				len_phase = (len_phase + 1) % PAD_ALIGNMENT;
				if (msg.last_byte) begin
					crc = crc_accum;
					pad = (len_phase == 0) ? 0 : PAD_ALIGNMENT - len_phase;
					for (int i = 0; i < pad; i++) begin
						crc = crc32c_shift_byte(crc, 8'h00);
					end
					expected_digests.push_back(crc ^ CRC_FINAL_XOR);
					crc_accum = CRC_INIT;
					len_phase = 0;
				end
			end
			if (dig.valid && dig.ready) begin
				if (expected_digests.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: digest %08h with none pending", $realtime, dig.digest);
				end else begin
					want = expected_digests.pop_front();
					digests_checked++;
					if (dig.digest !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: digest mismatch: expected %08h, got %08h",
								$realtime, want, dig.digest);
					end
				end
			end
		end
	end

	// Watchdog: abort after a long stretch with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (msg.valid && msg.ready) || (dig.valid && dig.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer", stall_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		msg.valid     = 1'b0;
		msg.data_byte = 8'h00;
		msg.last_byte = 1'b0;
		dig.ready     = 1'b0;

		// Directed: single-byte extremes, aligned length, each unaligned phase
		queue_message('{8'h00});
		queue_message('{8'hFF});
		queue_message('{8'hFF, 8'h00, 8'hAA, 8'h55});
		queue_message('{8'h01, 8'h80});
		queue_message('{8'h7F, 8'hFE, 8'h00});
		queue_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		queue_message('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38});

		// Random messages up to the byte budget
		while (pending_bytes.size() < TARGET_BYTES)
			queue_random_message();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_bytes.size() == 0 && !msg.valid && expected_digests.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (expected_digests.size() != 0)
			mismatches += expected_digests.size();

		$display("Sent %0d messages (%0d bytes), checked %0d digests, %0d mismatches,",
			messages_queued, bytes_accepted, digests_checked, mismatches);
		$display("with lengths at every alignment phase under three stall patterns.");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
